### src/iaws_pkg.sv
// Shared types and constants for the indexed key store with bubble sort.
// Depends on nothing; every other file of the block but iaws_ram uses it.
package iaws_pkg;

	localparam int CAPACITY      = 64;
	localparam int KEY_WIDTH     = 32;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int ADDR_W        = $clog2(CAPACITY);
	localparam int CMD_W         = 4;
	localparam int POS_W         = 7;
	localparam int KEY_FIELD_W   = 32;
	localparam int COUNT_FIELD_W = 7;
	localparam int STATUS_W      = 2;
	localparam int CMP_W         = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND     = 4'd0,
		CMD_PREPEND    = 4'd1,
		CMD_DROP_LAST  = 4'd2,
		CMD_DROP_FIRST = 4'd3,
		CMD_INSERT     = 4'd4,
		CMD_ERASE      = 4'd5,
		CMD_READ       = 4'd6,
		CMD_FRONT      = 4'd7,
		CMD_BACK       = 4'd8,
		CMD_SORT       = 4'd9
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_UP_RD,
		S_UP_WR,
		S_WR_KEY,
		S_DN_RD,
		S_DN_WR,
		S_DEC,
		S_RD_TAKE,
		S_SORT_LOAD,
		S_SORT_CMP,
		S_SORT_PASS,
		S_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_FAIL,
		OP_UP_RD,
		OP_UP_WR,
		OP_WRITE_KEY,
		OP_DN_RD,
		OP_DN_WR,
		OP_DEC_COUNT,
		OP_RD_ISSUE,
		OP_RD_TAKE,
		OP_SORT_START,
		OP_SORT_LOAD,
		OP_SORT_CMP,
		OP_SORT_PASS,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t fail_st;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic             empty;
		logic             full;
		logic             pos_gt;
		logic             pos_ge;
		logic             up_done;
		logic             up_last;
		logic             dn_done;
		logic             dn_last;
		logic             pass_last;
		logic             sort_last;
		logic             few;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} dp_stat_t;

endpackage

### src/iaws_if.sv
// Valid/ready channel interfaces for the command and result items.
// Depends on iaws_pkg for the field widths.
interface iaws_req_if;
	logic                             valid;
	logic                             ready;
	logic [iaws_pkg::CMD_W-1:0]       command;
	logic [iaws_pkg::POS_W-1:0]       position;
	logic [iaws_pkg::KEY_FIELD_W-1:0] key_in;

	modport source (output valid, command, position, key_in, input ready);
	modport sink (input valid, command, position, key_in, output ready);
endinterface

interface iaws_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [iaws_pkg::STATUS_W-1:0]      status;
	logic [iaws_pkg::KEY_FIELD_W-1:0]   key_out;
	logic [iaws_pkg::COUNT_FIELD_W-1:0] count;

	modport source (output valid, status, key_out, count, input ready);
	modport sink (input valid, status, key_out, count, output ready);
endinterface

### src/iaws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iaws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/iaws_ctrl.sv
// Sequencer for the key store: decodes each item and steps the datapath.
// Depends on iaws_pkg.
module iaws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  iaws_pkg::dp_stat_t stat,
	output iaws_pkg::dp_cmd_t  dp_cmd
);

	iaws_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iaws_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			iaws_pkg::S_IDLE: begin
				if (req_valid) state_d = iaws_pkg::S_DECODE;
			end
			iaws_pkg::S_DECODE: begin
				case (stat.cmd)
					iaws_pkg::CMD_APPEND, iaws_pkg::CMD_PREPEND,
					iaws_pkg::CMD_INSERT: begin
						if (stat.pos_gt || stat.full) state_d = iaws_pkg::S_FIN;
						else if (stat.up_done) state_d = iaws_pkg::S_WR_KEY;
						else state_d = iaws_pkg::S_UP_RD;
					end
					iaws_pkg::CMD_DROP_LAST: begin
						state_d = stat.empty ? iaws_pkg::S_FIN : iaws_pkg::S_DEC;
					end
					iaws_pkg::CMD_DROP_FIRST, iaws_pkg::CMD_ERASE: begin
						if (stat.pos_ge) state_d = iaws_pkg::S_FIN;
						else if (stat.dn_done) state_d = iaws_pkg::S_DEC;
						else state_d = iaws_pkg::S_DN_RD;
					end
					iaws_pkg::CMD_READ: begin
						state_d = stat.pos_ge ? iaws_pkg::S_FIN : iaws_pkg::S_RD_TAKE;
					end
					iaws_pkg::CMD_FRONT, iaws_pkg::CMD_BACK: begin
						state_d = stat.empty ? iaws_pkg::S_FIN : iaws_pkg::S_RD_TAKE;
					end
					iaws_pkg::CMD_SORT: begin
						state_d = stat.few ? iaws_pkg::S_FIN : iaws_pkg::S_SORT_LOAD;
					end
					default: state_d = iaws_pkg::S_FIN;
				endcase
			end
			iaws_pkg::S_UP_RD: state_d = iaws_pkg::S_UP_WR;
			iaws_pkg::S_UP_WR: begin
				state_d = stat.up_last ? iaws_pkg::S_WR_KEY : iaws_pkg::S_UP_RD;
			end
			iaws_pkg::S_WR_KEY: state_d = iaws_pkg::S_FIN;
			iaws_pkg::S_DN_RD: state_d = iaws_pkg::S_DN_WR;
			iaws_pkg::S_DN_WR: begin
				state_d = stat.dn_last ? iaws_pkg::S_DEC : iaws_pkg::S_DN_RD;
			end
			iaws_pkg::S_DEC: state_d = iaws_pkg::S_FIN;
			iaws_pkg::S_RD_TAKE: state_d = iaws_pkg::S_FIN;
			iaws_pkg::S_SORT_LOAD: state_d = iaws_pkg::S_SORT_CMP;
			iaws_pkg::S_SORT_CMP: begin
				if (stat.pass_last) state_d = iaws_pkg::S_SORT_PASS;
			end
			iaws_pkg::S_SORT_PASS: begin
				state_d = stat.sort_last ? iaws_pkg::S_FIN : iaws_pkg::S_SORT_LOAD;
			end
			iaws_pkg::S_FIN: begin
				if (stat.out_free) state_d = iaws_pkg::S_IDLE;
			end
			default: state_d = iaws_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready      = 1'b0;
		dp_cmd.op      = iaws_pkg::OP_NONE;
		dp_cmd.fail_st = iaws_pkg::ST_OK;
		case (state_q)
			iaws_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) dp_cmd.op = iaws_pkg::OP_CAPTURE;
			end
			iaws_pkg::S_DECODE: begin
				case (stat.cmd)
					iaws_pkg::CMD_APPEND, iaws_pkg::CMD_PREPEND,
					iaws_pkg::CMD_INSERT: begin
						if (stat.pos_gt) begin
							dp_cmd.op      = iaws_pkg::OP_FAIL;
							dp_cmd.fail_st = iaws_pkg::ST_RANGE;
						end else if (stat.full) begin
							dp_cmd.op      = iaws_pkg::OP_FAIL;
							dp_cmd.fail_st = iaws_pkg::ST_FULL;
						end
					end
					iaws_pkg::CMD_DROP_LAST, iaws_pkg::CMD_DROP_FIRST: begin
						if (stat.empty) begin
							dp_cmd.op      = iaws_pkg::OP_FAIL;
							dp_cmd.fail_st = iaws_pkg::ST_EMPTY;
						end
					end
					iaws_pkg::CMD_ERASE: begin
						if (stat.pos_ge) begin
							dp_cmd.op      = iaws_pkg::OP_FAIL;
							dp_cmd.fail_st = iaws_pkg::ST_RANGE;
						end
					end
					iaws_pkg::CMD_READ: begin
						if (stat.pos_ge) begin
							dp_cmd.op      = iaws_pkg::OP_FAIL;
							dp_cmd.fail_st = iaws_pkg::ST_RANGE;
						end else begin
							dp_cmd.op = iaws_pkg::OP_RD_ISSUE;
						end
					end
					iaws_pkg::CMD_FRONT, iaws_pkg::CMD_BACK: begin
						if (stat.empty) begin
							dp_cmd.op      = iaws_pkg::OP_FAIL;
							dp_cmd.fail_st = iaws_pkg::ST_EMPTY;
						end else begin
							dp_cmd.op = iaws_pkg::OP_RD_ISSUE;
						end
					end
					iaws_pkg::CMD_SORT: begin
						if (!stat.few) dp_cmd.op = iaws_pkg::OP_SORT_START;
					end
					default: dp_cmd.op = iaws_pkg::OP_NONE;
				endcase
			end
			iaws_pkg::S_UP_RD:     dp_cmd.op = iaws_pkg::OP_UP_RD;
			iaws_pkg::S_UP_WR:     dp_cmd.op = iaws_pkg::OP_UP_WR;
			iaws_pkg::S_WR_KEY:    dp_cmd.op = iaws_pkg::OP_WRITE_KEY;
			iaws_pkg::S_DN_RD:     dp_cmd.op = iaws_pkg::OP_DN_RD;
			iaws_pkg::S_DN_WR:     dp_cmd.op = iaws_pkg::OP_DN_WR;
			iaws_pkg::S_DEC:       dp_cmd.op = iaws_pkg::OP_DEC_COUNT;
			iaws_pkg::S_RD_TAKE:   dp_cmd.op = iaws_pkg::OP_RD_TAKE;
			iaws_pkg::S_SORT_LOAD: dp_cmd.op = iaws_pkg::OP_SORT_LOAD;
			iaws_pkg::S_SORT_CMP:  dp_cmd.op = iaws_pkg::OP_SORT_CMP;
			iaws_pkg::S_SORT_PASS: dp_cmd.op = iaws_pkg::OP_SORT_PASS;
			iaws_pkg::S_FIN: begin
				if (stat.out_free) dp_cmd.op = iaws_pkg::OP_FINISH;
			end
			default: dp_cmd.op = iaws_pkg::OP_NONE;
		endcase
	end

endmodule

### src/iaws_dp.sv
// Datapath of the key store: item registers, count, walk index, sort carry,
// the element RAM and the result register. Depends on iaws_pkg and iaws_ram.
module iaws_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [iaws_pkg::CMD_W-1:0]        command,
	input  logic [iaws_pkg::POS_W-1:0]        position,
	input  logic [iaws_pkg::KEY_FIELD_W-1:0]  key_in,
	input  iaws_pkg::dp_cmd_t                 dp_cmd,
	output iaws_pkg::dp_stat_t                stat,
	input  logic                              rsp_ready,
	output logic                              rsp_valid,
	output logic [iaws_pkg::STATUS_W-1:0]     status,
	output logic [iaws_pkg::KEY_FIELD_W-1:0]  key_out,
	output logic [iaws_pkg::COUNT_FIELD_W-1:0] count
);

	iaws_pkg::cmd_t                  cmd_q;
	logic [iaws_pkg::CMP_W-1:0]      pos_q;
	logic [iaws_pkg::KEY_WIDTH-1:0]  key_q;
	logic [iaws_pkg::CNT_W-1:0]      count_q;
	logic [iaws_pkg::CNT_W-1:0]      idx_q;
	logic [iaws_pkg::CNT_W-1:0]      limit_q;
	logic [iaws_pkg::KEY_WIDTH-1:0]  carry_q;
	iaws_pkg::status_t               res_st_q;
	logic [iaws_pkg::KEY_WIDTH-1:0]  rd_q;
	logic                            ovalid_q;
	iaws_pkg::status_t               ost_q;
	logic [iaws_pkg::KEY_WIDTH-1:0]  okey_q;
	logic [iaws_pkg::CNT_W-1:0]      ocount_q;

	logic [iaws_pkg::CMP_W-1:0]      cnt_x;
	logic [iaws_pkg::CMP_W-1:0]      idx_x;
	logic [iaws_pkg::CMP_W-1:0]      eff_pos;
	logic                            grow_cmd;
	logic [iaws_pkg::CNT_W:0]        idx_p1;
	logic [iaws_pkg::CNT_W:0]        idx_p2;
	logic [iaws_pkg::CNT_W:0]        cnt_w;
	logic                            ram_we;
	logic [iaws_pkg::ADDR_W-1:0]     ram_waddr;
	logic [iaws_pkg::KEY_WIDTH-1:0]  ram_wdata;
	logic [iaws_pkg::ADDR_W-1:0]     ram_raddr;
	logic [iaws_pkg::KEY_WIDTH-1:0]  ram_rdata;
	logic                            carry_gt;
	logic [iaws_pkg::CNT_W-1:0]      raddr_full;

	assign cnt_x  = iaws_pkg::CMP_W'(count_q);
	assign idx_x  = iaws_pkg::CMP_W'(idx_q);
	assign idx_p1 = (iaws_pkg::CNT_W + 1)'(idx_q) + 1'b1;
	assign idx_p2 = (iaws_pkg::CNT_W + 1)'(idx_q) + 2'd2;
	assign cnt_w  = (iaws_pkg::CNT_W + 1)'(count_q);

	// position the item works at, resolved from its command
	always_comb begin
		case (iaws_pkg::cmd_t'(command))
			iaws_pkg::CMD_APPEND:     eff_pos = cnt_x;
			iaws_pkg::CMD_PREPEND:    eff_pos = '0;
			iaws_pkg::CMD_DROP_FIRST: eff_pos = '0;
			iaws_pkg::CMD_FRONT:      eff_pos = '0;
			iaws_pkg::CMD_BACK:       eff_pos = cnt_x - 1'b1;
			default:                  eff_pos = iaws_pkg::CMP_W'(position);
		endcase
	end

	assign grow_cmd = (iaws_pkg::cmd_t'(command) == iaws_pkg::CMD_APPEND) ||
			(iaws_pkg::cmd_t'(command) == iaws_pkg::CMD_PREPEND) ||
			(iaws_pkg::cmd_t'(command) == iaws_pkg::CMD_INSERT);

	assign carry_gt = carry_q > ram_rdata;

	// RAM port steering
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = idx_q[iaws_pkg::ADDR_W-1:0];
		ram_wdata  = ram_rdata;
		raddr_full = idx_q;
		case (dp_cmd.op)
			iaws_pkg::OP_UP_RD:      raddr_full = idx_q - 1'b1;
			iaws_pkg::OP_DN_RD:      raddr_full = idx_p1[iaws_pkg::CNT_W-1:0];
			iaws_pkg::OP_RD_ISSUE:   raddr_full = iaws_pkg::CNT_W'(pos_q);
			iaws_pkg::OP_SORT_START: raddr_full = '0;
			iaws_pkg::OP_SORT_LOAD:  raddr_full = idx_p1[iaws_pkg::CNT_W-1:0];
			iaws_pkg::OP_UP_WR, iaws_pkg::OP_DN_WR: ram_we = 1'b1;
			iaws_pkg::OP_WRITE_KEY: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[iaws_pkg::ADDR_W-1:0];
				ram_wdata = key_q;
			end
			iaws_pkg::OP_SORT_CMP: begin
				ram_we     = 1'b1;
				ram_wdata  = carry_gt ? ram_rdata : carry_q;
				raddr_full = idx_p2[iaws_pkg::CNT_W-1:0];
			end
			iaws_pkg::OP_SORT_PASS: begin
				ram_we     = 1'b1;
				ram_wdata  = carry_q;
				raddr_full = '0;
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign ram_raddr = raddr_full[iaws_pkg::ADDR_W-1:0];

	iaws_ram #(
		.WIDTH(iaws_pkg::KEY_WIDTH),
		.DEPTH(iaws_pkg::CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			case (dp_cmd.op)
				iaws_pkg::OP_WRITE_KEY: count_q <= count_q + 1'b1;
				iaws_pkg::OP_DEC_COUNT: count_q <= count_q - 1'b1;
				default:                count_q <= count_q;
			endcase
			if (dp_cmd.op == iaws_pkg::OP_FINISH) begin
				ovalid_q <= 1'b1;
			end else if (rsp_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			iaws_pkg::OP_CAPTURE: begin
				cmd_q    <= iaws_pkg::cmd_t'(command);
				pos_q    <= eff_pos;
				key_q    <= iaws_pkg::KEY_WIDTH'(key_in);
				idx_q    <= grow_cmd ? count_q : iaws_pkg::CNT_W'(eff_pos);
				res_st_q <= iaws_pkg::ST_OK;
				rd_q     <= '0;
			end
			iaws_pkg::OP_FAIL:    res_st_q <= dp_cmd.fail_st;
			iaws_pkg::OP_UP_WR:   idx_q    <= idx_q - 1'b1;
			iaws_pkg::OP_DN_WR:   idx_q    <= idx_p1[iaws_pkg::CNT_W-1:0];
			iaws_pkg::OP_RD_TAKE: rd_q     <= ram_rdata;
			iaws_pkg::OP_SORT_START: begin
				idx_q   <= '0;
				limit_q <= count_q - 1'b1;
			end
			iaws_pkg::OP_SORT_LOAD: carry_q <= ram_rdata;
			iaws_pkg::OP_SORT_CMP: begin
				if (!carry_gt) carry_q <= ram_rdata;
				idx_q <= idx_p1[iaws_pkg::CNT_W-1:0];
			end
			iaws_pkg::OP_SORT_PASS: begin
				idx_q   <= '0;
				limit_q <= limit_q - 1'b1;
			end
			iaws_pkg::OP_FINISH: begin
				ost_q    <= res_st_q;
				okey_q   <= rd_q;
				ocount_q <= count_q;
			end
			default: rd_q <= rd_q;
		endcase
	end

	assign stat.cmd       = cmd_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == iaws_pkg::CNT_W'(iaws_pkg::CAPACITY));
	assign stat.pos_gt    = (pos_q > cnt_x);
	assign stat.pos_ge    = (pos_q >= cnt_x);
	assign stat.up_done   = (idx_x == pos_q);
	assign stat.up_last   = (idx_x == pos_q + 1'b1);
	assign stat.dn_done   = (idx_p1 >= cnt_w);
	assign stat.dn_last   = (idx_p2 >= cnt_w);
	assign stat.pass_last = (idx_p1 == (iaws_pkg::CNT_W + 1)'(limit_q));
	assign stat.sort_last = (limit_q == iaws_pkg::CNT_W'(1));
	assign stat.few       = (count_q < iaws_pkg::CNT_W'(2));
	assign stat.out_free  = !ovalid_q || rsp_ready;
	assign stat.count     = count_q;

	assign rsp_valid = ovalid_q;
	assign status    = ost_q;
	assign key_out   = iaws_pkg::KEY_FIELD_W'(okey_q);
	assign count     = iaws_pkg::COUNT_FIELD_W'(ocount_q);

endmodule

### src/indexed_array_with_sort.sv
// Top level of the indexed key store with bubble sort: one item at a time.
// Insert, prepend, erase and drop-first shift the entries one by one through the RAM; sort
// walks the RAM in bubble passes. A result not yet taken holds the sequencer before idle.
// The next item is taken in the cycle after the result register loads.
// arst_n clears the count, the sequencer and the output valid; the RAM is not cleared.
module indexed_array_with_sort (
	input  logic      clk,
	input  logic      arst_n,
	iaws_req_if.sink  req,
	iaws_rsp_if.source rsp
);

	// command and status between sequencer and datapath
	iaws_pkg::dp_cmd_t  dp_cmd;
	iaws_pkg::dp_stat_t dp_stat;

	// sequencer: accepts an item only from idle, then steps the datapath
	iaws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.stat     (dp_stat),
		.dp_cmd   (dp_cmd)
	);

	// datapath: element RAM, count, walk index, sort carry and result register
	iaws_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.command  (req.command),
		.position (req.position),
		.key_in   (req.key_in),
		.dp_cmd   (dp_cmd),
		.stat     (dp_stat),
		.rsp_ready(rsp.ready),
		.rsp_valid(rsp.valid),
		.status   (rsp.status),
		.key_out  (rsp.key_out),
		.count    (rsp.count)
	);

	// the count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.count <= iaws_pkg::CNT_W'(iaws_pkg::CAPACITY))
		else $error("element count above capacity");

	// one item in flight: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while previous one still at work");

	// finishing an item always presents a result
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.op == iaws_pkg::OP_FINISH |=> rsp.valid)
		else $error("finished item did not raise result valid");

	// a key write grows the store by exactly one
	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.op == iaws_pkg::OP_WRITE_KEY |=> dp_stat.count == $past(dp_stat.count) + 1'b1)
		else $error("key write did not advance the count");

endmodule
